// ===== design/assert_macros.svh =====
// Concurrent assertion helpers, sampled on i_clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcg_pkg.sv =====
package tcg_pkg;

    localparam int GLYPH_W_DEF        = 8;
    localparam int GLYPH_H_DEF        = 8;
    localparam int GLYPH_COUNT_DEF    = 256;
    localparam int MAX_TEXT_COLS_DEF  = 32;
    localparam int MAX_TEXT_LINES_DEF = 16;

    localparam int GLYPH_STRIDE   = 8;
    localparam int STRIDE_W       = 3;
    localparam int CELL_IDX_W     = 9;
    localparam int GLYPH_ADDR_W   = 11;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [5:0] TEXT_COLS_RST  = 6'd8;
    localparam logic [4:0] TEXT_LINES_RST = 5'd4;

    localparam logic [2:0] OP_PUT    = 3'd0;
    localparam logic [2:0] OP_CURSOR = 3'd1;
    localparam logic [2:0] OP_COLON  = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_GLYPH  = 3'd4;

    localparam logic [1:0] KIND_DRAW  = 2'd0;
    localparam logic [1:0] KIND_COLON = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_GLYPH = 2'd3;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] PAT_COLON  = 8'h66;
    localparam logic [7:0] PAT_DOT    = 8'h60;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_code;
        logic [4:0] cell_column;
        logic [3:0] cell_line;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] glyph_byte_index;
        logic [7:0] glyph_byte;
    } t_cmd_req;

    typedef struct packed {
        logic [7:0] pixel_x;
        logic [6:0] pixel_y;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       last_pixel;
    } t_pix_rsp;

    typedef struct packed {
        logic [1:0]              kind;
        logic [CELL_IDX_W-1:0]   cell_idx;
        logic [GLYPH_ADDR_W-1:0] gaddr;
        logic [7:0]              base_x;
        logic [6:0]              base_y;
        logic [7:0]              red;
        logic [7:0]              green;
        logic [7:0]              blue;
        logic [7:0]              data;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== design/tcg_cmd_if.sv =====
interface tcg_cmd_if;
    logic              valid;
    logic              ready;
    tcg_pkg::t_cmd_req req;

    modport source (output valid, output req, input ready);
    modport sink (input valid, input req, output ready);
endinterface

// ===== design/tcg_pix_if.sv =====
interface tcg_pix_if;
    logic              valid;
    logic              ready;
    tcg_pkg::t_pix_rsp rsp;

    modport source (output valid, output rsp, input ready);
    modport sink (input valid, input rsp, output ready);
endinterface

// ===== design/tcg_ram.sv =====
module tcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tcg_queue.sv =====
module tcg_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tcg_pkg::t_job    i_job,
    input  logic             i_pop,
    output tcg_pkg::t_job    o_job,
    output tcg_pkg::t_q_stat o_stat
);

    tcg_pkg::t_job r_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;
    logic          n_wptr;
    logic          n_rptr;
    logic [1:0]    n_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rptr];

    always_comb begin
        n_wptr  = do_push ? !r_wptr : r_wptr;
        n_rptr  = do_pop ? !r_rptr : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// ===== design/tcg_front.sv =====
module tcg_front #(
    parameter int GLYPH_W        = tcg_pkg::GLYPH_W_DEF,
    parameter int GLYPH_H        = tcg_pkg::GLYPH_H_DEF,
    parameter int GLYPH_COUNT    = tcg_pkg::GLYPH_COUNT_DEF,
    parameter int MAX_TEXT_COLS  = tcg_pkg::MAX_TEXT_COLS_DEF,
    parameter int MAX_TEXT_LINES = tcg_pkg::MAX_TEXT_LINES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcg_cmd_if.sink       i_cmd,
    input  logic [5:0]    i_text_columns,
    input  logic [4:0]    i_text_lines,
    input  logic          i_home,
    input  logic          i_q_full,
    input  logic          i_init_busy,
    output logic          o_push,
    output tcg_pkg::t_job o_job
);

    logic [4:0] r_col;
    logic [3:0] r_line;
    logic [4:0] n_col;
    logic [3:0] n_line;
    logic       n_push;
    logic [5:0] cols_eff;
    logic [4:0] lines_eff;
    logic [4:0] sel_col;
    logic [3:0] sel_line;
    logic [9:0] prod;
    logic [9:0] cell_sum;
    logic       in_panel;
    logic       code_ok;
    logic [7:0] draw_code;
    logic [5:0] col_next;
    logic [4:0] line_next;
    logic [7:0] pattern;
    logic       accept;
    tcg_pkg::t_cmd_req req;

    assign req         = i_cmd.req;
    assign i_cmd.ready = !i_q_full && !i_init_busy;
    assign accept      = i_cmd.valid && i_cmd.ready;

    always_comb begin
        priority if (i_text_columns == 6'd0) begin
            cols_eff = 6'd1;
        end else if (i_text_columns > 6'(MAX_TEXT_COLS)) begin
            cols_eff = 6'(MAX_TEXT_COLS);
        end else begin
            cols_eff = i_text_columns;
        end
        priority if (i_text_lines == 5'd0) begin
            lines_eff = 5'd1;
        end else if (i_text_lines > 5'(MAX_TEXT_LINES)) begin
            lines_eff = 5'(MAX_TEXT_LINES);
        end else begin
            lines_eff = i_text_lines;
        end
    end

    assign sel_col   = (req.opcode == tcg_pkg::OP_PUT) ? r_col : req.cell_column;
    assign sel_line  = (req.opcode == tcg_pkg::OP_PUT) ? r_line : req.cell_line;
    assign prod      = {6'd0, sel_line} * {4'd0, cols_eff};
    assign cell_sum  = prod + {5'd0, sel_col};
    assign in_panel  = ({1'b0, req.cell_column} < cols_eff) &&
                       ({1'b0, req.cell_line} < lines_eff);
    assign code_ok   = ({1'b0, req.char_code} < 9'(GLYPH_COUNT));
    assign draw_code = code_ok ? req.char_code : tcg_pkg::CHAR_SPACE;
    assign col_next  = {1'b0, r_col} + 6'd1;
    assign line_next = {1'b0, r_line} + 5'd1;

    always_comb begin
        priority if (req.char_code == tcg_pkg::CHAR_COLON ||
                     req.char_code == tcg_pkg::CHAR_SEMI) begin
            pattern = tcg_pkg::PAT_COLON;
        end else if (req.char_code == tcg_pkg::CHAR_DOT ||
                     req.char_code == tcg_pkg::CHAR_COMMA) begin
            pattern = tcg_pkg::PAT_DOT;
        end else begin
            pattern = 8'd0;
        end
    end

    always_comb begin
        n_col          = r_col;
        n_line         = r_line;
        n_push         = 1'b0;
        o_job.kind     = tcg_pkg::KIND_DRAW;
        o_job.cell_idx = cell_sum[tcg_pkg::CELL_IDX_W-1:0];
        o_job.gaddr    = {draw_code, {tcg_pkg::STRIDE_W{1'b0}}};
        o_job.base_x   = 8'({3'd0, r_col} * 8'(GLYPH_W));
        o_job.base_y   = 7'({3'd0, r_line} * 7'(GLYPH_H));
        o_job.red      = req.red;
        o_job.green    = req.green;
        o_job.blue     = req.blue;
        o_job.data     = pattern;
        unique case (req.opcode)
            tcg_pkg::OP_PUT: begin
                n_push = 1'b1;
                if (col_next >= cols_eff) begin
                    n_col  = 5'd0;
                    n_line = (line_next >= lines_eff) ? 4'd0 : line_next[3:0];
                end else begin
                    n_col = col_next[4:0];
                end
            end
            tcg_pkg::OP_CURSOR: begin
                if (in_panel) begin
                    n_col  = req.cell_column;
                    n_line = req.cell_line;
                end
            end
            tcg_pkg::OP_COLON: begin
                o_job.kind = tcg_pkg::KIND_COLON;
                n_push     = in_panel;
            end
            tcg_pkg::OP_CLEAR: begin
                o_job.kind = tcg_pkg::KIND_CLEAR;
                n_push     = 1'b1;
            end
            tcg_pkg::OP_GLYPH: begin
                o_job.kind  = tcg_pkg::KIND_GLYPH;
                o_job.gaddr = {req.char_code, req.glyph_byte_index};
                o_job.data  = req.glyph_byte;
                n_push      = code_ok && ({1'b0, req.glyph_byte_index} < 4'(GLYPH_W));
            end
            default: begin
                n_push = 1'b0;
            end
        endcase
    end

    assign o_push = accept && n_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= 5'd0;
            r_line <= 4'd0;
        end else if (i_home) begin
            r_col  <= 5'd0;
            r_line <= 4'd0;
        end else if (accept) begin
            r_col  <= n_col;
            r_line <= n_line;
        end
    end

endmodule

// ===== design/tcg_back.sv =====
module tcg_back #(
    parameter int GLYPH_W     = tcg_pkg::GLYPH_W_DEF,
    parameter int GLYPH_H     = tcg_pkg::GLYPH_H_DEF,
    parameter int GLYPH_COUNT = tcg_pkg::GLYPH_COUNT_DEF,
    parameter int CELL_DEPTH  = tcg_pkg::MAX_TEXT_COLS_DEF * tcg_pkg::MAX_TEXT_LINES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcg_pkg::t_job    i_job,
    input  tcg_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_init_busy,
    tcg_pix_if.source        o_pix
);

    localparam int GLYPH_DEPTH = GLYPH_COUNT * tcg_pkg::GLYPH_STRIDE;
    localparam int GA_W = $clog2(GLYPH_DEPTH);
    localparam int CI_W = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam int XW   = $clog2(GLYPH_W);
    localparam int YW   = $clog2(GLYPH_H);
    localparam int CW   = $clog2(GLYPH_W + 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    logic [CI_W-1:0] r_clr;
    logic [CI_W-1:0] n_clr;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic [XW-1:0]   r_px;
    logic [XW-1:0]   n_px;
    logic [YW-1:0]   r_py;
    logic [YW-1:0]   n_py;
    logic            r_ovalid;
    logic [GA_W-1:0] r_gaddr;
    logic [CI_W-1:0] r_cell;
    logic [7:0]      r_base_x;
    logic [6:0]      r_base_y;
    logic [7:0]      r_red;
    logic [7:0]      r_green;
    logic [7:0]      r_blue;
    logic [7:0]      r_glyph [GLYPH_W];
    logic [31:0]     r_ov;
    tcg_pkg::t_pix_rsp r_out;
    tcg_pkg::t_pix_rsp pix;

    logic            sweeping;
    logic            adv;
    logic            emit;
    logic            last_col;
    logic            last;
    logic            pop_draw;
    logic [CW-1:0]   rd_col;
    logic            g_we;
    logic [GA_W-1:0] g_raddr;
    logic [7:0]      g_rdata;
    logic            c_we;
    logic [CI_W-1:0] c_waddr;
    logic [31:0]     c_wdata;
    logic [31:0]     c_rdata;
    logic            show;
    logic            pix_on;
    logic [7:0]      gbyte;

    assign o_pop       = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_init_busy = (r_state == S_INIT);
    assign pop_draw    = o_pop && (i_job.kind == tcg_pkg::KIND_DRAW);
    assign sweeping    = (r_state == S_INIT) || (r_state == S_CLEAR);
    assign adv         = !r_ovalid || o_pix.ready;
    assign emit        = (r_state == S_EMIT) && adv;
    assign last_col    = (r_px == XW'(GLYPH_W - 1));
    assign last        = last_col && (r_py == YW'(GLYPH_H - 1));

    assign rd_col  = (r_cnt < CW'(GLYPH_W)) ? r_cnt : '0;
    assign g_we    = o_pop && (i_job.kind == tcg_pkg::KIND_GLYPH);
    assign g_raddr = r_gaddr + GA_W'(rd_col);
    assign c_we    = sweeping || (o_pop && (i_job.kind == tcg_pkg::KIND_COLON));
    assign c_waddr = sweeping ? r_clr : i_job.cell_idx[CI_W-1:0];
    assign c_wdata = sweeping ? 32'd0 : {i_job.data, i_job.red, i_job.green, i_job.blue};

    tcg_ram #(
        .WIDTH(8),
        .DEPTH(GLYPH_DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (i_job.gaddr[GA_W-1:0]),
        .i_wdata (i_job.data),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    tcg_ram #(
        .WIDTH(32),
        .DEPTH(CELL_DEPTH)
    ) u_colon_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (r_cell),
        .o_rdata (c_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_cnt   = r_cnt;
        n_px    = r_px;
        n_py    = r_py;
        unique case (r_state)
            S_INIT, S_CLEAR: begin
                n_clr = r_clr + CI_W'(1);
                if (r_clr == CI_W'(CELL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                    n_clr   = '0;
                end
            end
            S_IDLE: begin
                if (o_pop && i_job.kind == tcg_pkg::KIND_CLEAR) begin
                    n_state = S_CLEAR;
                    n_clr   = '0;
                end else if (pop_draw) begin
                    n_state = S_LOAD;
                    n_cnt   = '0;
                end
            end
            S_LOAD: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(GLYPH_W)) begin
                    n_state = S_EMIT;
                    n_px    = '0;
                    n_py    = '0;
                end
            end
            S_EMIT: begin
                if (adv) begin
                    if (last_col) begin
                        n_px = '0;
                        n_py = r_py + YW'(1);
                        if (last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_px = r_px + XW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign show  = (r_ov[31:24] != 8'd0);
    assign gbyte = r_glyph[r_px];

    always_comb begin
        pix.pixel_x    = r_base_x + 8'(r_px);
        pix.pixel_y    = r_base_y + 7'(r_py);
        pix.last_pixel = last;
        if (show && last_col) begin
            pix_on          = r_ov[24 + 32'(r_py)];
            pix.pixel_red   = pix_on ? r_ov[23:16] : 8'd0;
            pix.pixel_green = pix_on ? r_ov[15:8] : 8'd0;
            pix.pixel_blue  = pix_on ? r_ov[7:0] : 8'd0;
        end else begin
            pix_on          = gbyte[r_py];
            pix.pixel_red   = pix_on ? r_red : 8'd0;
            pix.pixel_green = pix_on ? r_green : 8'd0;
            pix.pixel_blue  = pix_on ? r_blue : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_px    <= n_px;
            r_py    <= n_py;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_pix.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_draw) begin
            r_gaddr  <= i_job.gaddr[GA_W-1:0];
            r_cell   <= i_job.cell_idx[CI_W-1:0];
            r_base_x <= i_job.base_x;
            r_base_y <= i_job.base_y;
            r_red    <= i_job.red;
            r_green  <= i_job.green;
            r_blue   <= i_job.blue;
        end
        if (r_state == S_LOAD && r_cnt != '0) begin
            r_glyph[XW'(r_cnt - CW'(1))] <= g_rdata;
        end
        if (r_state == S_LOAD && r_cnt == CW'(GLYPH_W)) begin
            r_ov <= c_rdata;
        end
        if (emit) begin
            r_out <= pix;
        end
    end

    assign o_pix.valid = r_ovalid;
    assign o_pix.rsp   = r_out;

endmodule

// ===== design/text_cell_glyph_renderer_unit.sv =====
// Channel   Dir  Handshake      Payload
// i_cmd     in   valid/ready    opcode, char, cell, color, glyph byte
// o_pix     out  valid/ready    pixel x/y, color, last pixel flag
// apb       in   psel/penable   text_columns @0x0, text_lines @0x4
//
// Draw command: dispatch, then glyph fetch from the glyph RAM, then GLYPH_W*GLYPH_H
// pixels of output, one pixel per cycle while o_pix.ready does not stall the output.
// Clear-overlay command: sweeps all MAX_TEXT_COLS*MAX_TEXT_LINES cells of the overlay RAM.
// Other commands are written when popped, and the back end stays idle; no-op commands never reach it.
// After reset the overlay RAM is swept the same way with i_cmd.ready low.
// A two-entry request queue lets the front end keep taking requests while pixels stall.
`include "assert_macros.svh"

module text_cell_glyph_renderer_unit #(
    parameter int GLYPH_W        = tcg_pkg::GLYPH_W_DEF,
    parameter int GLYPH_H        = tcg_pkg::GLYPH_H_DEF,
    parameter int GLYPH_COUNT    = tcg_pkg::GLYPH_COUNT_DEF,
    parameter int MAX_TEXT_COLS  = tcg_pkg::MAX_TEXT_COLS_DEF,
    parameter int MAX_TEXT_LINES = tcg_pkg::MAX_TEXT_LINES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tcg_cmd_if.sink                         i_cmd,
    tcg_pix_if.source                       o_pix,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tcg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tcg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int CELL_DEPTH = MAX_TEXT_COLS * MAX_TEXT_LINES;

    logic [5:0]       r_text_columns;
    logic [4:0]       r_text_lines;
    logic             cfg_wr;
    logic             job_push;
    logic             job_pop;
    logic             init_busy;
    tcg_pkg::t_job    push_job;
    tcg_pkg::t_job    head_job;
    tcg_pkg::t_q_stat q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[1:0] != 2'd0) ? '0 :
                    paddr[2] ? tcg_pkg::APB_DATA_W'(r_text_lines) :
                               tcg_pkg::APB_DATA_W'(r_text_columns);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_columns <= tcg_pkg::TEXT_COLS_RST;
            r_text_lines   <= tcg_pkg::TEXT_LINES_RST;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_text_lines <= pwdata[4:0];
            end else begin
                r_text_columns <= pwdata[5:0];
            end
        end
    end

    tcg_front #(
        .GLYPH_W        (GLYPH_W),
        .GLYPH_H        (GLYPH_H),
        .GLYPH_COUNT    (GLYPH_COUNT),
        .MAX_TEXT_COLS  (MAX_TEXT_COLS),
        .MAX_TEXT_LINES (MAX_TEXT_LINES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_text_columns (r_text_columns),
        .i_text_lines   (r_text_lines),
        .i_home         (cfg_wr),
        .i_q_full       (q_stat.full),
        .i_init_busy    (init_busy),
        .o_push         (job_push),
        .o_job          (push_job)
    );

    tcg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (push_job),
        .i_pop   (job_pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    tcg_back #(
        .GLYPH_W     (GLYPH_W),
        .GLYPH_H     (GLYPH_H),
        .GLYPH_COUNT (GLYPH_COUNT),
        .CELL_DEPTH  (CELL_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_stat    (q_stat),
        .o_pop       (job_pop),
        .o_init_busy (init_busy),
        .o_pix       (o_pix)
    );

    `ASSERT_HOLDS(a_no_push_full, !(q_stat.full && job_push), "request pushed into full queue")
    `ASSERT_HOLDS(a_no_pop_empty, !(q_stat.empty && job_pop), "request popped from empty queue")
    `ASSERT_HOLDS(a_no_accept_init, !(init_busy && job_push), "request queued during overlay init")
    `ASSERT_NEXT(a_push_lands, job_push && !job_pop, !q_stat.empty, "queued request lost")

endmodule
